// ===== hw/rtl/cor_pkg.sv =====
// Shared widths, reset values and pipeline carry types for the circle overlap unit.
// No dependencies; used by circle_overlap_resolution_unit by scoped names.
`default_nettype none
package cor_pkg;

  localparam int COORD_W    = 32;
  localparam int RAD_W      = COORD_W - 1;
  localparam int ROOT_W     = 32;
  localparam int SQ_W       = 2 * ROOT_W;
  localparam int GAIN_W     = 17;
  localparam int GAIN_FRAC  = 16;
  localparam int PART_W     = ROOT_W + GAIN_W;
  localparam int NUM_W      = SQ_W + GAIN_W;
  localparam int QUO_W      = ROOT_W + GAIN_W;
  localparam int MAG_W      = QUO_W - GAIN_FRAC;
  localparam int SQ_STAGES  = ROOT_W;
  localparam int DIV_STAGES = QUO_W;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(24576);

  // Fields carried alongside the square-root stages.
  typedef struct packed {
    logic [ROOT_W-1:0] adx;
    logic [ROOT_W-1:0] ady;
    logic              neg_x;
    logic              neg_y;
    logic [ROOT_W-1:0] rsum;
    logic              ovl;
    logic              coin;
  } sq_carry_t;

  // Fields carried alongside the divider stages.
  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic              neg_x;
    logic              neg_y;
    logic              ovl;
    logic              coin;
  } dv_carry_t;

endpackage
`default_nettype wire

// ===== hw/rtl/circle_overlap_resolution_unit.sv =====
// Top level of the circle overlap unit: a fully pipelined narrow-phase pair check.
// Depends on cor_pkg for widths, reset values and the carry structs.
`default_nettype none
// Usage:
// A transaction is one circle pair, presented on the in_ ports with start high.
// busy is always low, so a new pair is taken in every clock cycle. Each pair gives
// exactly one result, shown on the out_ ports for a single cycle with out_valid high
// once the pair has passed every stage; the receiver takes it at the following edge.
// Results leave in the order pairs arrived.
// Throughput is one pair per cycle; the square root settles one root bit per stage
// (32 stages), and the two dividers, which run side by side, settle one quotient bit
// per stage (49 stages each).
// The gain register is written through cfg_we / cfg_wdata and should only change
// while no pair is in flight. Synchronous reset (rst_n low) clears every valid bit
// and loads the gain with 0.375; data registers are not reset.
// The receiver cannot hold results off, so there is no stall path: the valid bits
// simply march through the pipeline with their data.
// Stages: absolute differences, squares, overlap compare, square root, overlap
// times axis, gain partial products, partial sum, long division, saturation.
module circle_overlap_resolution_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic signed [cor_pkg::COORD_W-1:0] in_first_x,
  input  wire logic signed [cor_pkg::COORD_W-1:0] in_first_y,
  input  wire logic        [cor_pkg::RAD_W-1:0]   in_first_radius,
  input  wire logic signed [cor_pkg::COORD_W-1:0] in_second_x,
  input  wire logic signed [cor_pkg::COORD_W-1:0] in_second_y,
  input  wire logic        [cor_pkg::RAD_W-1:0]   in_second_radius,
  input  wire logic                             cfg_we,
  input  wire logic        [cor_pkg::GAIN_W-1:0]  cfg_wdata,
  output logic                                  out_valid,
  output logic                                  out_overlapping,
  output logic signed [cor_pkg::COORD_W-1:0]     out_push_x,
  output logic signed [cor_pkg::COORD_W-1:0]     out_push_y,
  output logic                                  out_coincident
);

  localparam int CW = cor_pkg::COORD_W;
  localparam int RW = cor_pkg::ROOT_W;
  localparam int SW = cor_pkg::SQ_W;
  localparam int GW = cor_pkg::GAIN_W;
  localparam int PW = cor_pkg::PART_W;
  localparam int NW = cor_pkg::NUM_W;
  localparam int QW = cor_pkg::QUO_W;
  localparam int MW = cor_pkg::MAG_W;
  localparam int SQN = cor_pkg::SQ_STAGES;
  localparam int DVN = cor_pkg::DIV_STAGES;

  // Nothing ever blocks the pipeline.
  assign busy = 1'b0;

  logic [GW-1:0] gain_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= cor_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      gain_r <= cfg_wdata;
    end
  end

  // Stage A: center differences as magnitude plus sign, radius sum.
  logic signed [CW:0] dx_a, dy_a;
  assign dx_a = $signed({in_first_x[CW-1], in_first_x})
                - $signed({in_second_x[CW-1], in_second_x});
  assign dy_a = $signed({in_first_y[CW-1], in_first_y})
                - $signed({in_second_y[CW-1], in_second_y});

  logic          a_vld_r;
  logic [CW:0]   a_adx_r, a_ady_r;
  logic          a_nx_r, a_ny_r;
  logic [RW-1:0] a_rsum_r;
  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else        a_vld_r <= start;
    a_adx_r  <= dx_a[CW] ? (CW+1)'(-dx_a) : (CW+1)'(dx_a);
    a_ady_r  <= dy_a[CW] ? (CW+1)'(-dy_a) : (CW+1)'(dy_a);
    a_nx_r   <= dx_a[CW];
    a_ny_r   <= dy_a[CW];
    a_rsum_r <= RW'(in_first_radius) + RW'(in_second_radius);
  end

  // Stage B: squares. A difference of 2^32 or more can never overlap, since the
  // radius sum stays below 2^32, so only the low 32 bits need squaring.
  logic          b_vld_r, b_far_r, b_coin_r, b_nx_r, b_ny_r;
  logic [SW-1:0] b_sqx_r, b_sqy_r, b_rsq_r;
  logic [RW-1:0] b_adx_r, b_ady_r, b_rsum_r;
  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else        b_vld_r <= a_vld_r;
    b_far_r  <= a_adx_r[CW] | a_ady_r[CW];
    b_coin_r <= (a_adx_r == '0) && (a_ady_r == '0);
    b_sqx_r  <= SW'(a_adx_r[RW-1:0]) * SW'(a_adx_r[RW-1:0]);
    b_sqy_r  <= SW'(a_ady_r[RW-1:0]) * SW'(a_ady_r[RW-1:0]);
    b_rsq_r  <= SW'(a_rsum_r) * SW'(a_rsum_r);
    b_adx_r  <= a_adx_r[RW-1:0];
    b_ady_r  <= a_ady_r[RW-1:0];
    b_rsum_r <= a_rsum_r;
    b_nx_r   <= a_nx_r;
    b_ny_r   <= a_ny_r;
  end

  // Stage C: squared distance and the overlap decision; feeds the root pipeline.
  logic [SW:0] s_c;
  assign s_c = {1'b0, b_sqx_r} + {1'b0, b_sqy_r};

  logic                 sq_vld_r [SQN+1];
  logic [SW-1:0]        sq_x_r   [SQN+1];
  logic [SW-1:0]        sq_res_r [SQN+1];
  cor_pkg::sq_carry_t   sq_c_r   [SQN+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_vld_r[0] <= 1'b0;
    else        sq_vld_r[0] <= b_vld_r;
    sq_x_r[0]        <= s_c[SW-1:0];
    sq_res_r[0]      <= '0;
    sq_c_r[0].adx    <= b_adx_r;
    sq_c_r[0].ady    <= b_ady_r;
    sq_c_r[0].neg_x  <= b_nx_r;
    sq_c_r[0].neg_y  <= b_ny_r;
    sq_c_r[0].rsum   <= b_rsum_r;
    sq_c_r[0].ovl    <= !b_far_r && (s_c < {1'b0, b_rsq_r});
    sq_c_r[0].coin   <= b_coin_r;
  end

  // Square root, one result bit per stage. When the pair does not overlap the
  // squared distance may exceed 64 bits; the root is then unused.
  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    localparam logic [SW-1:0] ONE = SW'(1) << (SW - 2 - 2 * k);
    logic [SW-1:0] trial;
    logic          take;
    assign trial = sq_res_r[k] + ONE;
    assign take  = sq_x_r[k] >= trial;
    always_ff @(posedge clk) begin
      if (!rst_n) sq_vld_r[k+1] <= 1'b0;
      else        sq_vld_r[k+1] <= sq_vld_r[k];
      sq_x_r[k+1]   <= take ? sq_x_r[k] - trial : sq_x_r[k];
      sq_res_r[k+1] <= take ? (sq_res_r[k] >> 1) + ONE : sq_res_r[k] >> 1;
      sq_c_r[k+1]   <= sq_c_r[k];
    end
  end

  // Stage D: overlap = rsum - dist, then overlap times each axis magnitude.
  cor_pkg::sq_carry_t sq_o;
  logic [RW-1:0]      dist_d, overlap_d;
  assign sq_o      = sq_c_r[SQN];
  assign dist_d    = sq_res_r[SQN][RW-1:0];
  assign overlap_d = sq_o.rsum - dist_d;

  logic               d_vld_r;
  logic [SW-1:0]      d_mx_r, d_my_r;
  cor_pkg::dv_carry_t d_c_r;
  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else        d_vld_r <= sq_vld_r[SQN];
    d_mx_r      <= SW'(overlap_d) * SW'(sq_o.adx);
    d_my_r      <= SW'(overlap_d) * SW'(sq_o.ady);
    d_c_r.root  <= dist_d;
    d_c_r.neg_x <= sq_o.neg_x;
    d_c_r.neg_y <= sq_o.neg_y;
    d_c_r.ovl   <= sq_o.ovl;
    d_c_r.coin  <= sq_o.coin;
  end

  // Stage E: gain applied as two 32-by-17 partial products per axis.
  logic               e_vld_r;
  logic [PW-1:0]      e_xlo_r, e_xhi_r, e_ylo_r, e_yhi_r;
  cor_pkg::dv_carry_t e_c_r;
  always_ff @(posedge clk) begin
    if (!rst_n) e_vld_r <= 1'b0;
    else        e_vld_r <= d_vld_r;
    e_xlo_r <= PW'(d_mx_r[RW-1:0])  * PW'(gain_r);
    e_xhi_r <= PW'(d_mx_r[SW-1:RW]) * PW'(gain_r);
    e_ylo_r <= PW'(d_my_r[RW-1:0])  * PW'(gain_r);
    e_yhi_r <= PW'(d_my_r[SW-1:RW]) * PW'(gain_r);
    e_c_r   <= d_c_r;
  end

  // Stage F: partial sums give the dividends; the top bits seed the remainders.
  logic [NW-1:0] num_x_f, num_y_f;
  assign num_x_f = {e_xhi_r, RW'(0)} + NW'(e_xlo_r);
  assign num_y_f = {e_yhi_r, RW'(0)} + NW'(e_ylo_r);

  logic               dv_vld_r  [DVN+1];
  logic [RW-1:0]      dv_rx_r   [DVN+1];
  logic [RW-1:0]      dv_ry_r   [DVN+1];
  logic [QW-1:0]      dv_nx_r   [DVN+1];
  logic [QW-1:0]      dv_ny_r   [DVN+1];
  logic [QW-1:0]      dv_qx_r   [DVN+1];
  logic [QW-1:0]      dv_qy_r   [DVN+1];
  cor_pkg::dv_carry_t dv_c_r    [DVN+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else        dv_vld_r[0] <= e_vld_r;
    dv_rx_r[0] <= num_x_f[NW-1:QW];
    dv_ry_r[0] <= num_y_f[NW-1:QW];
    dv_nx_r[0] <= num_x_f[QW-1:0];
    dv_ny_r[0] <= num_y_f[QW-1:0];
    dv_qx_r[0] <= '0;
    dv_qy_r[0] <= '0;
    dv_c_r[0]  <= e_c_r;
  end

  // Restoring long division, one quotient bit per stage for both axes. The
  // quotient is bounded by overlap times gain, so 49 bits cover it.
  for (genvar i = 0; i < DVN; i++) begin : g_div
    logic [RW:0] tx, ty;
    logic        bx, by;
    assign tx = {dv_rx_r[i], dv_nx_r[i][QW-1]};
    assign ty = {dv_ry_r[i], dv_ny_r[i][QW-1]};
    assign bx = tx >= {1'b0, dv_c_r[i].root};
    assign by = ty >= {1'b0, dv_c_r[i].root};
    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[i+1] <= 1'b0;
      else        dv_vld_r[i+1] <= dv_vld_r[i];
      dv_rx_r[i+1] <= bx ? RW'(tx - {1'b0, dv_c_r[i].root}) : RW'(tx);
      dv_ry_r[i+1] <= by ? RW'(ty - {1'b0, dv_c_r[i].root}) : RW'(ty);
      dv_nx_r[i+1] <= dv_nx_r[i] << 1;
      dv_ny_r[i+1] <= dv_ny_r[i] << 1;
      dv_qx_r[i+1] <= {dv_qx_r[i][QW-2:0], bx};
      dv_qy_r[i+1] <= {dv_qy_r[i][QW-2:0], by};
      dv_c_r[i+1]  <= dv_c_r[i];
    end
  end

  // Stage G: drop the gain fraction, saturate, apply the sign, register results.
  // The second circle moves opposite to dx = first - second; when dx is negative
  // the push is positive and tops out at 2^31-1, otherwise it bottoms at -2^31.
  cor_pkg::dv_carry_t dv_o;
  logic               act_g;
  logic [MW-1:0]      qmx_g, qmy_g, capx_g, capy_g;
  logic [CW-1:0]      magx_g, magy_g;
  assign dv_o   = dv_c_r[DVN];
  assign act_g  = dv_o.ovl && !dv_o.coin;
  assign qmx_g  = dv_qx_r[DVN][QW-1:cor_pkg::GAIN_FRAC];
  assign qmy_g  = dv_qy_r[DVN][QW-1:cor_pkg::GAIN_FRAC];
  assign capx_g = dv_o.neg_x ? MW'((MW'(1) << (CW - 1)) - MW'(1)) : MW'(1) << (CW - 1);
  assign capy_g = dv_o.neg_y ? MW'((MW'(1) << (CW - 1)) - MW'(1)) : MW'(1) << (CW - 1);
  assign magx_g = (qmx_g > capx_g) ? CW'(capx_g) : CW'(qmx_g);
  assign magy_g = (qmy_g > capy_g) ? CW'(capy_g) : CW'(qmy_g);

  logic          out_vld_r, out_ovl_r, out_coin_r;
  logic [CW-1:0] out_px_r, out_py_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= dv_vld_r[DVN];
    out_ovl_r  <= dv_o.ovl;
    out_coin_r <= dv_o.coin;
    out_px_r   <= !act_g ? '0 : (dv_o.neg_x ? magx_g : CW'(-magx_g));
    out_py_r   <= !act_g ? '0 : (dv_o.neg_y ? magy_g : CW'(-magy_g));
  end

  assign out_valid       = out_vld_r;
  assign out_overlapping = out_ovl_r;
  assign out_coincident  = out_coin_r;
  assign out_push_x      = $signed(out_px_r);
  assign out_push_y      = $signed(out_py_r);

endmodule
`default_nettype wire
